>>> sv/psrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrf_pkg
// shared types and constants of the printable string run finder
// ----------------------------------------------------------------------------
package psrf_pkg;

   localparam int MaxSections = 16;
   localparam int SecIdxBits  = $clog2(MaxSections);
   localparam int OffsetBits  = 32;
   localparam int RunQDepth   = 4;
   localparam int RunQBits    = $clog2(RunQDepth);

   localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

   // configuration register indexes
   localparam logic [1:0] CsrMinLength    = 2'd0;
   localparam logic [1:0] CsrSectionCount = 2'd1;
   localparam logic [1:0] CsrTablePresent = 2'd2;

   // input opcodes
   localparam logic OpData = 1'b0;
   localparam logic OpLoad = 1'b1;

   // location tags
   localparam logic [1:0] TagSection = 2'd0;
   localparam logic [1:0] TagGap     = 2'd1;
   localparam logic [1:0] TagUnknown = 2'd2;

   // one found run, passed from the scanner to the tagger
   typedef struct packed {
      logic        kind;
      logic [OffsetBits-1:0] start;
      logic [31:0] count;
      logic        last;
   } run_rec_type;

   function automatic logic printable(input logic [7:0] b);
      printable = (b >= 8'h20) && (b <= 8'h7E);
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == CntMax) ? v : v + 32'd1;
   endfunction

endpackage

>>> sv/psrf_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrf_scanner
// front part: runs both detectors on each data byte, pushes found runs
// ----------------------------------------------------------------------------
module psrf_scanner (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_valid,
   input  logic [7:0]               data_byte,
   input  logic                     is_last,
   input  logic [15:0]              min_length,
   output logic                     rec_push,
   output psrf_pkg::run_rec_type    rec_data,
   input  logic                     rec_hold,
   output logic                     busy
);

   logic [psrf_pkg::OffsetBits-1:0] byte_offset_ff, byte_offset_in;
   logic [31:0] ascii_length_ff, ascii_length_in;
   logic [7:0]  prev_byte_ff, prev_byte_in;
   logic        prev_valid_ff, prev_valid_in;
   logic        wide_in_run_ff, wide_in_run_in;
   logic        wide_phase_ff, wide_phase_in;
   logic [psrf_pkg::OffsetBits-1:0] wide_start_ff, wide_start_in;
   logic [31:0] wide_count_ff, wide_count_in;

   // second record of one byte waits here until the queue has room
   logic                  pend_ff, pend_in;
   psrf_pkg::run_rec_type pend_rec_ff, pend_rec_in;

   psrf_pkg::run_rec_type rec0, rec1, rec_swap;
   logic        n0, n1;
   logic [31:0] minl;
   logic        pr;
   logic [psrf_pkg::OffsetBits-1:0] pos, pos1;
   logic        w_ended;
   logic        a_emit, w_emit, fa_emit, fw_emit;
   logic [31:0] a_len_new;

   assign busy = pend_ff;

   // detector logic
   always_comb begin
      minl = (min_length == 16'd0) ? 32'd1 : {16'd0, min_length};
      pr   = psrf_pkg::printable(data_byte);
      pos  = byte_offset_ff;
      pos1 = pos + 1'b1;

      a_len_new = pr ? psrf_pkg::sat_inc(ascii_length_ff) : 32'd0;
      a_emit = !pr && (ascii_length_ff >= minl);

      wide_in_run_in = wide_in_run_ff;
      wide_phase_in  = wide_phase_ff;
      wide_start_in  = wide_start_ff;
      wide_count_in  = wide_count_ff;
      w_ended = 1'b0;
      if (wide_in_run_ff) begin
         if (!wide_phase_ff) begin
            if (pr) wide_phase_in = 1'b1;
            else w_ended = 1'b1;
         end else begin
            if (data_byte == 8'h00) begin
               wide_count_in = psrf_pkg::sat_inc(wide_count_ff);
               wide_phase_in = 1'b0;
            end else begin
               w_ended = 1'b1;
            end
         end
         if (w_ended) begin
            wide_in_run_in = 1'b0;
            wide_phase_in  = 1'b0;
         end
      end else if (prev_valid_ff && psrf_pkg::printable(prev_byte_ff) &&
                   data_byte == 8'h00) begin
         wide_in_run_in = 1'b1;
         wide_phase_in  = 1'b0;
         wide_start_in  = (pos == '0) ? '0 : pos - 1'b1;
         wide_count_in  = 32'd1;
      end
      w_emit = w_ended && (wide_count_ff >= minl);

      prev_byte_in  = wide_in_run_in ? prev_byte_ff : data_byte;
      prev_valid_in = !wide_in_run_in;

      fa_emit = is_last && (a_len_new >= minl);
      fw_emit = is_last && wide_in_run_in && (wide_count_in >= minl);

      // gather up to two records (at most two can be set together)
      rec0 = '0;
      rec1 = '0;
      rec_swap = '0;
      n0 = 1'b0;
      n1 = 1'b0;
      if (a_emit) begin
         n0 = 1'b1;
         rec0.kind  = 1'b0;
         rec0.start = ({32'd0, ascii_length_ff} > {32'd0, pos}) ? '0
                      : pos - ascii_length_ff[psrf_pkg::OffsetBits-1:0];
         rec0.count = ascii_length_ff;
      end
      if (w_emit) begin
         if (!n0) begin
            n0 = 1'b1;
            rec0.kind = 1'b1; rec0.start = wide_start_ff; rec0.count = wide_count_ff;
         end else begin
            n1 = 1'b1;
            rec1.kind = 1'b1; rec1.start = wide_start_ff; rec1.count = wide_count_ff;
         end
      end
      if (fa_emit) begin
         if (!n0) begin
            n0 = 1'b1;
            rec0.kind = 1'b0;
            rec0.start = ({32'd0, a_len_new} > {32'd0, pos1}) ? '0
                         : pos1 - a_len_new[psrf_pkg::OffsetBits-1:0];
            rec0.count = a_len_new;
         end else begin
            n1 = 1'b1;
            rec1.kind = 1'b0;
            rec1.start = ({32'd0, a_len_new} > {32'd0, pos1}) ? '0
                         : pos1 - a_len_new[psrf_pkg::OffsetBits-1:0];
            rec1.count = a_len_new;
         end
      end
      if (fw_emit && !n1) begin
         if (!n0) begin
            n0 = 1'b1;
            rec0.kind = 1'b1; rec0.start = wide_start_in; rec0.count = wide_count_in;
         end else begin
            n1 = 1'b1;
            rec1.kind = 1'b1; rec1.start = wide_start_in; rec1.count = wide_count_in;
         end
      end
      // order by start, single-byte first on a tie
      if (n1 && ((rec1.start < rec0.start) ||
                 (rec1.start == rec0.start && rec1.kind < rec0.kind))) begin
         rec_swap = rec0;
         rec0 = rec1;
         rec1 = rec_swap;
      end
      rec0.last = !n1;
      rec1.last = 1'b1;

      ascii_length_in = a_len_new;
      byte_offset_in  = (byte_offset_ff == '1) ? byte_offset_ff : pos1;
      if (is_last) begin
         byte_offset_in  = '0;
         ascii_length_in = '0;
         prev_byte_in    = '0;
         prev_valid_in   = 1'b0;
         wide_in_run_in  = 1'b0;
         wide_phase_in   = 1'b0;
         wide_start_in   = '0;
         wide_count_in   = '0;
      end

      // queue side: pending record goes first
      pend_in     = pend_ff;
      pend_rec_in = pend_rec_ff;
      rec_push    = 1'b0;
      rec_data    = rec0;
      if (pend_ff) begin
         if (!rec_hold) begin
            rec_push = 1'b1;
            rec_data = pend_rec_ff;
            pend_in  = 1'b0;
         end
      end else if (byte_valid && n0) begin
         rec_push = 1'b1;
         rec_data = rec0;
         if (n1) begin
            pend_in     = 1'b1;
            pend_rec_in = rec1;
         end
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff  <= '0;
         ascii_length_ff <= '0;
         prev_byte_ff    <= '0;
         prev_valid_ff   <= 1'b0;
         wide_in_run_ff  <= 1'b0;
         wide_phase_ff   <= 1'b0;
         wide_start_ff   <= '0;
         wide_count_ff   <= '0;
         pend_ff         <= 1'b0;
      end else begin
         if (byte_valid) begin
            byte_offset_ff  <= byte_offset_in;
            ascii_length_ff <= ascii_length_in;
            prev_byte_ff    <= prev_byte_in;
            prev_valid_ff   <= prev_valid_in;
            wide_in_run_ff  <= wide_in_run_in;
            wide_phase_ff   <= wide_phase_in;
            wide_start_ff   <= wide_start_in;
            wide_count_ff   <= wide_count_in;
         end
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_rec_ff <= pend_rec_in;
   end

endmodule

>>> sv/psrf_run_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrf_run_queue
// short queue of found runs between scanner and tagger
// ----------------------------------------------------------------------------
module psrf_run_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  psrf_pkg::run_rec_type push_data,
   input  logic                  pop,
   output psrf_pkg::run_rec_type head,
   output logic                  nonempty,
   output logic [psrf_pkg::RunQBits:0] level
);

   psrf_pkg::run_rec_type mem [psrf_pkg::RunQDepth];
   logic [psrf_pkg::RunQBits-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [psrf_pkg::RunQBits:0]   cnt_ff, cnt_in;

   assign head     = mem[rd_ff];
   assign nonempty = (cnt_ff != '0);
   assign level    = cnt_ff;

   // pointer update
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{psrf_pkg::RunQBits{1'b0}}, push}
                      - {{psrf_pkg::RunQBits{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_data;
   end

endmodule

>>> sv/psrf_tagger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrf_tagger
// back part: walks the section table for one run, then holds the result item
// ----------------------------------------------------------------------------
module psrf_tagger (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   input  logic [3:0]            entry_index,
   input  logic [31:0]           entry_start,
   input  logic [31:0]           entry_size,
   input  logic [63:0]           entry_name,
   input  logic [4:0]            section_count,
   input  logic                  table_present,
   input  logic                  run_avail,
   input  psrf_pkg::run_rec_type run_head,
   output logic                  run_take,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_run_kind,
   output logic [31:0]           rsp_start_offset,
   output logic [31:0]           rsp_char_count,
   output logic [1:0]            rsp_location_tag,
   output logic [3:0]            rsp_section_index,
   output logic [63:0]           rsp_section_name,
   output logic                  rsp_last_of_run,
   output logic                  idle
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] starts_mem [psrf_pkg::MaxSections];
   logic [31:0] sizes_mem  [psrf_pkg::MaxSections];
   logic [63:0] names_mem  [psrf_pkg::MaxSections];

   psrf_pkg::run_rec_type cur_ff, cur_in;
   logic [psrf_pkg::SecIdxBits:0]   idx_ff, idx_in, lim;
   logic [psrf_pkg::SecIdxBits-1:0] rd_idx;
   logic [31:0] ent_s, ent_e;
   logic        hit;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  tag_ff, tag_in;
   logic [3:0]  sidx_ff, sidx_in;
   logic [63:0] sname_ff, sname_in;
   logic        out_free;

   assign rd_idx = idx_ff[psrf_pkg::SecIdxBits-1:0];
   assign lim = (section_count > 5'(psrf_pkg::MaxSections))
                ? (psrf_pkg::SecIdxBits+1)'(psrf_pkg::MaxSections)
                : (psrf_pkg::SecIdxBits+1)'(section_count);

   // one entry compare per cycle
   always_comb begin
      ent_s = starts_mem[rd_idx];
      ent_e = starts_mem[rd_idx] + sizes_mem[rd_idx];
      hit   = (cur_ff.start >= ent_s) && (cur_ff.start < ent_e);
   end

   assign out_free  = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign idle      = (state_ff == ST_IDLE) && !out_valid_ff;

   // lookup sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      tag_in       = tag_ff;
      sidx_in      = sidx_ff;
      sname_in     = sname_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      run_take     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (run_avail) begin
               run_take = 1'b1;
               cur_in   = run_head;
               idx_in   = '0;
               sidx_in  = '0;
               sname_in = '0;
               tag_in   = table_present ? psrf_pkg::TagGap : psrf_pkg::TagUnknown;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!table_present || idx_ff >= lim) begin
               state_in = ST_DONE;
            end else if (hit) begin
               tag_in   = psrf_pkg::TagSection;
               sidx_in  = 4'(idx_ff);
               sname_in = names_mem[rd_idx];
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      idx_ff   <= idx_in;
      tag_ff   <= tag_in;
      sidx_ff  <= sidx_in;
      sname_ff <= sname_in;
   end

   // result register, loaded when the lookup finishes
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_run_kind      <= cur_ff.kind;
         rsp_start_offset  <= cur_ff.start[31:0];
         rsp_char_count    <= cur_ff.count;
         rsp_location_tag  <= tag_ff;
         rsp_section_index <= sidx_ff;
         rsp_section_name  <= sname_ff;
         rsp_last_of_run   <= cur_ff.last;
      end
   end

   // section table
   always_ff @(posedge clock) begin
      if (load_valid) begin
         starts_mem[entry_index[psrf_pkg::SecIdxBits-1:0]] <= entry_start;
         sizes_mem[entry_index[psrf_pkg::SecIdxBits-1:0]]  <= entry_size;
         names_mem[entry_index[psrf_pkg::SecIdxBits-1:0]]  <= entry_name;
      end
   end

endmodule

>>> sv/printable_string_run_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printable_string_run_finder
// finds printable single-byte and UTF-16LE runs, tags them by section
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  req       req_push / req_full           item taken on push && !full
//  rsp       rsp_pop / rsp_empty           item taken on pop && !empty
//  csr       csr_valid / csr_ready         write on valid && ready
//
// the scanner takes one byte per cycle while req_full is low; a byte that
// ends two runs stalls the input until its second record is pushed. each
// run then passes the tagger in steps (take, one compare per table entry
// until a hit, finish, load result), with section_count capped at 16; the
// run queue (4 deep) absorbs bursts, and req_full rises when it can fill. load
// items write the table only once the back is idle and the queue is empty.
// reset is synchronous; the section table is not cleared.
// ----------------------------------------------------------------------------
module printable_string_run_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_last,
   input  logic [3:0]  req_entry_index,
   input  logic [31:0] req_entry_start,
   input  logic [31:0] req_entry_size,
   input  logic [63:0] req_entry_name,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_run_kind,
   output logic [31:0] rsp_start_offset,
   output logic [31:0] rsp_char_count,
   output logic [1:0]  rsp_location_tag,
   output logic [3:0]  rsp_section_index,
   output logic [63:0] rsp_section_name,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] min_length_ff;
   logic [4:0]  section_count_ff;
   logic        table_present_ff;

   logic        accept, byte_valid, load_valid;
   logic        rec_push, rec_hold, scan_busy, q_nonempty, run_take, back_idle;
   psrf_pkg::run_rec_type rec_data, q_head;
   logic [psrf_pkg::RunQBits:0] q_level;

   // room for two records guarantees a byte never overflows the queue
   assign rec_hold = (q_level >= (psrf_pkg::RunQBits+1)'(psrf_pkg::RunQDepth));
   assign req_full = scan_busy ||
                     (q_level > (psrf_pkg::RunQBits+1)'(psrf_pkg::RunQDepth - 2)) ||
                     (req_opcode == psrf_pkg::OpLoad && (!back_idle || q_nonempty));
   assign accept     = req_push && !req_full;
   assign byte_valid = accept && req_opcode == psrf_pkg::OpData;
   assign load_valid = accept && req_opcode == psrf_pkg::OpLoad;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff    <= 16'd4;
         section_count_ff <= 5'd0;
         table_present_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            psrf_pkg::CsrMinLength:    min_length_ff    <= csr_data;
            psrf_pkg::CsrSectionCount: section_count_ff <= csr_data[4:0];
            psrf_pkg::CsrTablePresent: table_present_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   psrf_scanner u_scanner (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .data_byte  (req_data_byte),
      .is_last    (req_is_last),
      .min_length (min_length_ff),
      .rec_push   (rec_push),
      .rec_data   (rec_data),
      .rec_hold   (rec_hold),
      .busy       (scan_busy)
   );

   psrf_run_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_data),
      .pop       (run_take),
      .head      (q_head),
      .nonempty  (q_nonempty),
      .level     (q_level)
   );

   psrf_tagger u_tagger (
      .clock             (clock),
      .reset             (reset),
      .load_valid        (load_valid),
      .entry_index       (req_entry_index),
      .entry_start       (req_entry_start),
      .entry_size        (req_entry_size),
      .entry_name        (req_entry_name),
      .section_count     (section_count_ff),
      .table_present     (table_present_ff),
      .run_avail         (q_nonempty),
      .run_head          (q_head),
      .run_take          (run_take),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_run_kind      (rsp_run_kind),
      .rsp_start_offset  (rsp_start_offset),
      .rsp_char_count    (rsp_char_count),
      .rsp_location_tag  (rsp_location_tag),
      .rsp_section_index (rsp_section_index),
      .rsp_section_name  (rsp_section_name),
      .rsp_last_of_run   (rsp_last_of_run),
      .idle              (back_idle)
   );

   // queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(rec_push && q_level == (psrf_pkg::RunQBits+1)'(psrf_pkg::RunQDepth) && !run_take))
      else $error("run queue overflow");

   // a load item is only taken with the back part idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      load_valid |-> (back_idle && !q_nonempty))
      else $error("table written during lookup");

   // a pending second record blocks input
   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      scan_busy |-> req_full)
      else $error("input taken while record pending");

endmodule

>>> dv/psrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrf_checker
// watches the req, rsp and csr channels of the run finder, predicts every
// reported run from its own copy of the scan state, section table and
// registers, and compares each popped item field by field in order
// ----------------------------------------------------------------------------
module psrf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_last,
   input  logic [3:0]  req_entry_index,
   input  logic [31:0] req_entry_start,
   input  logic [31:0] req_entry_size,
   input  logic [63:0] req_entry_name,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic        rsp_run_kind,
   input  logic [31:0] rsp_start_offset,
   input  logic [31:0] rsp_char_count,
   input  logic [1:0]  rsp_location_tag,
   input  logic [3:0]  rsp_section_index,
   input  logic [63:0] rsp_section_name,
   input  logic        rsp_last_of_run,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct {
      logic        kind;
      logic [31:0] start;
      logic [31:0] count;
   } found_run_type;

   typedef struct {
      logic        kind;
      logic [31:0] start;
      logic [31:0] count;
      logic [1:0]  tag;
      logic [3:0]  sec_idx;
      logic [63:0] name_bytes;
      logic        last;
   } run_report_type;

   run_report_type expected_runs[$];

   // register copies
   logic [15:0] min_len;
   logic [4:0]  sec_count;
   logic        table_on;

   // scan state copies
   logic [31:0] byte_off;
   logic [31:0] text_len;
   logic [7:0]  prev_b;
   logic        prev_v;
   logic        wide_on;
   logic        wide_odd;
   logic [31:0] wide_start;
   logic [31:0] wide_len;

   // section table copy
   logic [31:0] sec_start[psrf_pkg::MaxSections];
   logic [31:0] sec_size[psrf_pkg::MaxSections];
   logic [63:0] tbl_name[psrf_pkg::MaxSections];

   assign pending = expected_runs.size();

   function automatic logic is_print(input logic [7:0] b);
      return b >= 8'h20 && b <= 8'h7E;
   endfunction

   function automatic logic [31:0] floor_sub(input logic [31:0] a, input logic [31:0] b);
      return (b > a) ? 32'd0 : a - b;
   endfunction

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == psrf_pkg::CntMax) ? v : v + 32'd1;
   endfunction

   task automatic clear_scan();
      byte_off = '0; text_len = '0; prev_b = '0; prev_v = 1'b0;
      wide_on = 1'b0; wide_odd = 1'b0; wide_start = '0; wide_len = '0;
   endtask

   // look the run up in the table and queue its report
   task automatic queue_report(input found_run_type r, input logic last);
      run_report_type rep;
      int lim;
      logic [31:0] e;
      rep.kind = r.kind; rep.start = r.start; rep.count = r.count;
      rep.tag = psrf_pkg::TagUnknown; rep.sec_idx = '0; rep.name_bytes = '0;
      rep.last = last;
      if (table_on) begin
         rep.tag = psrf_pkg::TagGap;
         lim = (sec_count > psrf_pkg::MaxSections) ? psrf_pkg::MaxSections : sec_count;
         for (int i = 0; i < lim; i++) begin
            e = sec_start[i] + sec_size[i];
            if (rep.tag == psrf_pkg::TagGap && r.start >= sec_start[i] && r.start < e) begin
               rep.tag = psrf_pkg::TagSection;
               rep.sec_idx = 4'(i);
               rep.name_bytes = tbl_name[i];
            end
         end
      end
      expected_runs.push_back(rep);
   endtask

   // one data byte through both detectors
   task automatic scan_byte(input logic [7:0] b, input logic last);
      found_run_type runs[2];
      found_run_type t;
      int n;
      logic [31:0] pos, minl;
      logic pr, ended;
      n = 0;
      pos = byte_off;
      pr = is_print(b);
      minl = (min_len == 16'd0) ? 32'd1 : {16'd0, min_len};

      // single-byte runs
      if (pr) begin
         text_len = bump(text_len);
      end else begin
         if (text_len >= minl) begin
            runs[n] = '{1'b0, floor_sub(pos, text_len), text_len};
            n++;
         end
         text_len = '0;
      end

      // utf-16le runs
      if (wide_on) begin
         ended = 1'b0;
         if (!wide_odd) begin
            if (pr) wide_odd = 1'b1;
            else ended = 1'b1;
         end else if (b == 8'h00) begin
            wide_len = bump(wide_len);
            wide_odd = 1'b0;
         end else begin
            ended = 1'b1;
         end
         if (ended) begin
            if (wide_len >= minl) begin
               runs[n] = '{1'b1, wide_start, wide_len};
               n++;
            end
            wide_on = 1'b0;
            wide_odd = 1'b0;
         end
      end else if (prev_v && is_print(prev_b) && b == 8'h00) begin
         wide_on = 1'b1;
         wide_odd = 1'b0;
         wide_start = floor_sub(pos, 32'd1);
         wide_len = 32'd1;
      end

      if (wide_on) begin
         prev_v = 1'b0;
      end else begin
         prev_b = b;
         prev_v = 1'b1;
      end

      // end of stream flushes open runs
      if (last) begin
         if (text_len >= minl) begin
            runs[n] = '{1'b0, floor_sub(pos + 32'd1, text_len), text_len};
            n++;
         end
         if (wide_on && wide_len >= minl && n < 2) begin
            runs[n] = '{1'b1, wide_start, wide_len};
            n++;
         end
         clear_scan();
      end else if (byte_off != 32'hFFFF_FFFF) begin
         byte_off++;
      end

      if (n == 2 && (runs[1].start < runs[0].start ||
                     (runs[1].start == runs[0].start && runs[1].kind < runs[0].kind))) begin
         t = runs[0]; runs[0] = runs[1]; runs[1] = t;
      end
      for (int k = 0; k < n; k++) queue_report(runs[k], k == n - 1);
   endtask

   task automatic check_field(input string fname, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, fname, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      run_report_type exp_r;
      if (reset) begin
         fail_count = 0;
         min_len = 16'd4;
         sec_count = '0;
         table_on = 1'b0;
         clear_scan();
         expected_runs.delete();
      end else begin
         // popped item against the oldest prediction
         if (rsp_pop && !rsp_empty) begin
            if (expected_runs.size() == 0) begin
               $display("%0t: unexpected item: expected none, actual start %0h count %0h",
                        $time, rsp_start_offset, rsp_char_count);
               fail_count++;
            end else begin
               exp_r = expected_runs.pop_front();
               check_field("run_kind", exp_r.kind, rsp_run_kind);
               check_field("start_offset", exp_r.start, rsp_start_offset);
               check_field("char_count", exp_r.count, rsp_char_count);
               check_field("location_tag", exp_r.tag, rsp_location_tag);
               check_field("section_index", exp_r.sec_idx, rsp_section_index);
               check_field("section_name", exp_r.name_bytes, rsp_section_name);
               check_field("last_of_run", exp_r.last, rsp_last_of_run);
            end
         end
         // accepted input item
         if (req_push && !req_full) begin
            if (req_opcode == psrf_pkg::OpLoad) begin
               sec_start[req_entry_index] = req_entry_start;
               sec_size[req_entry_index] = req_entry_size;
               tbl_name[req_entry_index] = req_entry_name;
            end else begin
               scan_byte(req_data_byte, req_is_last);
            end
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               psrf_pkg::CsrMinLength: min_len = csr_data;
               psrf_pkg::CsrSectionCount: sec_count = csr_data[4:0];
               psrf_pkg::CsrTablePresent: table_on = csr_data[0];
               default: ;
            endcase
         end
      end
   end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the run finder with directed and random byte streams and section
// loads over several register settings; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_top;

   localparam int IdleLimit = 20000;
   localparam int DrainCycles = 80;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_opcode;
   logic [7:0]  req_data_byte;
   logic        req_is_last;
   logic [3:0]  req_entry_index;
   logic [31:0] req_entry_start;
   logic [31:0] req_entry_size;
   logic [63:0] req_entry_name;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_run_kind;
   logic [31:0] rsp_start_offset;
   logic [31:0] rsp_char_count;
   logic [1:0]  rsp_location_tag;
   logic [3:0]  rsp_section_index;
   logic [63:0] rsp_section_name;
   logic        rsp_last_of_run;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;
   int          fail_count;
   int          pending;

   int burst_left;
   int idle_cycles = 0;
   int stall_left = 0;
   int pop_mode = 0;
   int mode_left = 0;

   printable_string_run_finder dut (.*);
   psrf_checker checker_i (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // send one item, with burst gaps in front of it
   task automatic send_item(input logic op, input logic [7:0] b, input logic last,
                            input logic [3:0] idx, input logic [31:0] st,
                            input logic [31:0] sz, input logic [63:0] nm);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_push <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_opcode <= op;
      req_data_byte <= b;
      req_is_last <= last;
      req_entry_index <= idx;
      req_entry_start <= st;
      req_entry_size <= sz;
      req_entry_name <= nm;
      req_push <= 1;
      do @(posedge clock); while (req_full);
      burst_left--;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      send_item(psrf_pkg::OpData, b, last, 4'($urandom), $urandom, $urandom,
                {$urandom, $urandom});
   endtask

   task automatic send_load(input logic [3:0] idx, input logic last);
      logic [31:0] st, sz;
      case ($urandom_range(0, 7))
         0: begin st = $urandom; sz = $urandom; end
         1: begin st = 32'hFFFF_FF00 + $urandom_range(0, 255); sz = $urandom_range(256, 4096); end
         2: begin st = 0; sz = 0; end
         default: begin st = $urandom_range(0, 300); sz = $urandom_range(1, 120); end
      endcase
      send_item(psrf_pkg::OpLoad, 8'($urandom), last, idx, st, sz, {$urandom, $urandom});
   endtask

   // wait for the block to go quiet before touching the registers
   task automatic drain();
      req_push <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic set_regs(input logic [15:0] minl, input logic [4:0] cnt, input logic tbl);
      drain();
      csr_write(psrf_pkg::CsrMinLength, minl);
      csr_write(psrf_pkg::CsrSectionCount, {11'd0, cnt});
      csr_write(psrf_pkg::CsrTablePresent, {15'd0, tbl});
   endtask

   // random stream: text runs, wide runs, noise, loads and stream ends
   task automatic random_items(input int count);
      int sent, len;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               len = $urandom_range(1, 12);
               repeat (len) send_byte(8'($urandom_range(8'h20, 8'h7E)),
                                      $urandom_range(0, 39) == 0);
               sent += len;
            end
            3, 4, 5: begin
               len = $urandom_range(1, 8);
               repeat (len) begin
                  send_byte(8'($urandom_range(8'h20, 8'h7E)), 0);
                  send_byte(8'h00, $urandom_range(0, 39) == 0);
               end
               if ($urandom_range(0, 2) == 0) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1);
               sent += 2 * len;
            end
            6: begin
               send_load(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
               sent++;
            end
            default: begin
               len = $urandom_range(1, 4);
               repeat (len) send_byte(8'($urandom), $urandom_range(0, 29) == 0);
               sent += len;
            end
         endcase
      end
   endtask

   // receiver stall pattern: free running, light stalls or long stalls
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_pop <= 0;
      end else begin
         rsp_pop <= 1;
         if (mode_left == 0) begin
            pop_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (pop_mode == 1 && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
         if (pop_mode == 2 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 12);
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset <= 1;
      req_push <= 0;
      req_opcode <= psrf_pkg::OpData;
      req_data_byte <= 0;
      req_is_last <= 0;
      req_entry_index <= 0;
      req_entry_start <= 0;
      req_entry_size <= 0;
      req_entry_name <= 0;
      csr_valid <= 0;
      csr_index <= psrf_pkg::CsrMinLength;
      csr_data <= 0;
      burst_left = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings, text run ended by a zero byte
      send_byte("A", 0); send_byte(8'h20, 0); send_byte(8'h7E, 0); send_byte("z", 0);
      send_byte(8'h00, 0);
      // non printable edges
      send_byte(8'h1F, 0); send_byte(8'h7F, 0); send_byte(8'hFF, 0);
      // wide run flushed at stream end
      send_byte("w", 0); send_byte(8'h00, 0); send_byte("i", 0); send_byte(8'h00, 0);
      send_byte("d", 0); send_byte(8'h00, 0); send_byte("e", 0); send_byte(8'h00, 1);
      // text run flushed at stream end
      send_byte("a", 0); send_byte("b", 0); send_byte("c", 0); send_byte("d", 0);
      send_byte("e", 1);
      // fill the whole table, one load flagged as last
      for (int i = 0; i < psrf_pkg::MaxSections; i++) send_load(4'(i), i == 3);

      set_regs(16'd1, 5'd16, 1'b1);
      random_items(110);
      set_regs(16'd0, 5'd5, 1'b1);
      random_items(100);
      set_regs(16'd3, 5'd0, 1'b1);
      random_items(90);
      set_regs(16'd2, 5'd16, 1'b0);
      random_items(90);
      set_regs(16'hFFFF, 5'd8, 1'b1);
      random_items(60);
      set_regs(16'd1, 5'd1, 1'b1);
      random_items(100);
      set_regs(16'd4, 5'd16, 1'b1);
      random_items(80);

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
